// File: rtl/core/gtcf_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// gtcf_pkg
// Shared types, codes and helpers for the GIF transparency clear filter.
// ----------------------------------------------------------------------------
package gtcf_pkg;

	// parse phase codes
	localparam logic [3:0] PH_HEADER   = 4'd0;
	localparam logic [3:0] PH_GPAL     = 4'd1;
	localparam logic [3:0] PH_INTRO    = 4'd2;
	localparam logic [3:0] PH_IMGDESC  = 4'd3;
	localparam logic [3:0] PH_LPAL     = 4'd4;
	localparam logic [3:0] PH_LZWSIZE  = 4'd5;
	localparam logic [3:0] PH_EXTTYPE  = 4'd6;
	localparam logic [3:0] PH_SUBLEN   = 4'd7;
	localparam logic [3:0] PH_SUBDATA  = 4'd8;
	localparam logic [3:0] PH_DONE     = 4'd9;
	localparam logic [3:0] PH_BADSIG   = 4'd10;
	localparam logic [3:0] PH_BADINTRO = 4'd11;

	// status codes
	localparam logic [1:0] ST_PARSING  = 2'd0;
	localparam logic [1:0] ST_TRAILER  = 2'd1;
	localparam logic [1:0] ST_BADSIG   = 2'd2;
	localparam logic [1:0] ST_BADINTRO = 2'd3;

	// block introducers and markers
	localparam logic [7:0] CH_TRAILER = 8'h3B;
	localparam logic [7:0] CH_IMAGE   = 8'h2C;
	localparam logic [7:0] CH_EXT     = 8'h21;
	localparam logic [7:0] EXT_GCE    = 8'hF9;
	localparam logic [7:0] GCE_LEN    = 8'h04;
	localparam logic [7:0] TRANS_MASK = 8'hFE;

	// screen descriptor layout
	localparam logic [9:0] SIG_LEN     = 10'd4;
	localparam logic [9:0] SD_PACKED   = 10'd10;
	localparam logic [9:0] SD_LAST     = 10'd12;
	localparam logic [9:0] ID_LAST     = 10'd8;

	// register index
	localparam logic REG_CLEAR_ENABLE = 1'b0;

	typedef logic [9:0] count_t;

	// "GIF8"
	function automatic logic [7:0] sig_byte(input logic [1:0] idx);
		logic [7:0] v;
		case (idx)
			2'd0:    v = 8'h47;
			2'd1:    v = 8'h49;
			2'd2:    v = 8'h46;
			default: v = 8'h38;
		endcase
		return v;
	endfunction

	// palette size in bytes from a packed flag byte
	function automatic count_t palette_bytes(input logic [7:0] packed_b);
		count_t base;
		base = 10'd3;
		if (!packed_b[7])
			return 10'd0;
		return base << ({1'b0, packed_b[2:0]} + 4'd1);
	endfunction

endpackage
`default_nettype wire

// File: rtl/core/gif_transparency_clear_filter_top.sv
`default_nettype none
// ----------------------------------------------------------------------------
// gif_transparency_clear_filter_top
// Byte-stream GIF parser that clears the transparency flag of GCE blocks.
// ----------------------------------------------------------------------------
// The block takes a GIF file one byte per item on the slave stream and hands
// every byte on over the master stream, one result item per input item, in
// order. It checks the "GIF8" signature, walks the screen descriptor,
// palettes, image descriptors, extensions and sub-block chains, and, while
// clear_enable is 1, clears bit 0 of the first data byte of every 4-byte
// sub-block inside a Graphic Control Extension. A byte with s_tuser high
// starts a new file. Each result carries the status after that byte (parsing,
// trailer, bad signature, unknown introducer) and a sticky changed flag; after
// the trailer or an error, bytes pass unchanged and status holds until the
// next start. Rate: one item per clock unless m_tready stalls the output.
// The parse step is a single pass of logic between the parse state registers
// and the output register, and the input is ready whenever the output register
// is empty or being taken, so results are registered. clear_enable resets to 1.
// ----------------------------------------------------------------------------
module gif_transparency_clear_filter_top (
	input  wire logic        clk,
	input  wire logic        arst_n,
	// input stream
	input  wire logic        s_tvalid,
	output logic             s_tready,
	input  wire logic [7:0]  s_tdata,   // [7:0] in_byte
	input  wire logic        s_tuser,   // [0] start_file
	// output stream
	output logic             m_tvalid,
	input  wire logic        m_tready,
	output logic [15:0]      m_tdata,   // [7:0] out_byte, [9:8] status, [10] changed
	// config port
	input  wire logic        psel,
	input  wire logic        penable,
	input  wire logic        pwrite,
	input  wire logic [2:0]  paddr,
	input  wire logic [31:0] pwdata,
	output logic [31:0]      prdata,
	output logic             pready
);

	// parse state
	logic [3:0]      phase_q;
	gtcf_pkg::count_t byte_count_q;
	gtcf_pkg::count_t pal_len_q;
	logic            in_gce_q;
	logic            clear_next_q;
	logic            changed_q;
	logic            clear_enable_q;

	// output register
	logic [7:0]      out_byte_s1;
	logic [1:0]      status_s1;
	logic            changed_s1;
	logic            valid_s1;

	logic            accept;
	logic            cfg_wr;

	// state seen by this byte, after a possible restart
	logic [3:0]      c_phase;
	gtcf_pkg::count_t c_bc;
	gtcf_pkg::count_t c_pal;
	logic            c_gce;
	logic            c_cn;
	logic            c_chg;

	// next state
	logic [3:0]      ph_n;
	gtcf_pkg::count_t bc_n;
	gtcf_pkg::count_t pal_n;
	gtcf_pkg::count_t bc_inc;
	logic            gce_n;
	logic            cn_n;
	logic            chg_n;
	logic [7:0]      ob;
	logic [1:0]      st;
	logic [7:0]      b;

	assign b        = s_tdata;
	assign s_tready = !valid_s1 || m_tready;
	assign accept   = s_tvalid && s_tready;

	// ---- config port: one register, no wait states ----
	assign pready = 1'b1;
	assign cfg_wr = psel && penable && pwrite && pready;
	assign prdata = (paddr[2] == gtcf_pkg::REG_CLEAR_ENABLE) ?
		{31'd0, clear_enable_q} : 32'd0;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			clear_enable_q <= 1'b1;
		end else if (cfg_wr && paddr[2] == gtcf_pkg::REG_CLEAR_ENABLE) begin
			clear_enable_q <= pwdata[0];
		end
	end

	// ---- parse step ----
	always_comb begin
		if (s_tuser) begin
			c_phase = gtcf_pkg::PH_HEADER;
			c_bc    = '0;
			c_pal   = '0;
			c_gce   = 1'b0;
			c_cn    = 1'b0;
			c_chg   = 1'b0;
		end else begin
			c_phase = phase_q;
			c_bc    = byte_count_q;
			c_pal   = pal_len_q;
			c_gce   = in_gce_q;
			c_cn    = clear_next_q;
			c_chg   = changed_q;
		end

		ph_n   = c_phase;
		bc_n   = c_bc;
		pal_n  = c_pal;
		gce_n  = c_gce;
		cn_n   = c_cn;
		chg_n  = c_chg;
		ob     = b;
		bc_inc = c_bc + 10'd1;

		case (c_phase)
			gtcf_pkg::PH_HEADER: begin
				if (c_bc < gtcf_pkg::SIG_LEN && b != gtcf_pkg::sig_byte(c_bc[1:0])) begin
					ph_n = gtcf_pkg::PH_BADSIG;
				end else begin
					if (c_bc == gtcf_pkg::SD_PACKED)
						pal_n = gtcf_pkg::palette_bytes(b);
					if (c_bc >= gtcf_pkg::SD_LAST) begin
						bc_n = '0;
						ph_n = (pal_n != '0) ? gtcf_pkg::PH_GPAL : gtcf_pkg::PH_INTRO;
					end else begin
						bc_n = bc_inc;
					end
				end
			end
			gtcf_pkg::PH_GPAL, gtcf_pkg::PH_LPAL: begin
				bc_n = bc_inc;
				if (bc_inc >= c_pal) begin
					bc_n = '0;
					ph_n = (c_phase == gtcf_pkg::PH_GPAL) ?
						gtcf_pkg::PH_INTRO : gtcf_pkg::PH_LZWSIZE;
				end
			end
			gtcf_pkg::PH_INTRO: begin
				if (b == gtcf_pkg::CH_TRAILER) begin
					ph_n = gtcf_pkg::PH_DONE;
				end else if (b == gtcf_pkg::CH_IMAGE) begin
					bc_n = '0;
					ph_n = gtcf_pkg::PH_IMGDESC;
				end else if (b == gtcf_pkg::CH_EXT) begin
					ph_n = gtcf_pkg::PH_EXTTYPE;
				end else begin
					ph_n = gtcf_pkg::PH_BADINTRO;
				end
			end
			gtcf_pkg::PH_IMGDESC: begin
				if (c_bc >= gtcf_pkg::ID_LAST) begin
					pal_n = gtcf_pkg::palette_bytes(b);
					bc_n  = '0;
					ph_n  = (pal_n != '0) ? gtcf_pkg::PH_LPAL : gtcf_pkg::PH_LZWSIZE;
				end else begin
					bc_n = bc_inc;
				end
			end
			gtcf_pkg::PH_LZWSIZE: begin
				gce_n = 1'b0;
				ph_n  = gtcf_pkg::PH_SUBLEN;
			end
			gtcf_pkg::PH_EXTTYPE: begin
				gce_n = (b == gtcf_pkg::EXT_GCE);
				ph_n  = gtcf_pkg::PH_SUBLEN;
			end
			gtcf_pkg::PH_SUBLEN: begin
				if (b == 8'd0) begin
					gce_n = 1'b0;
					ph_n  = gtcf_pkg::PH_INTRO;
				end else begin
					bc_n = {2'b00, b};
					cn_n = c_gce && (b == gtcf_pkg::GCE_LEN);
					ph_n = gtcf_pkg::PH_SUBDATA;
				end
			end
			gtcf_pkg::PH_SUBDATA: begin
				// first byte of a GCE block holds the transparency flag
				if (c_cn) begin
					if (clear_enable_q) begin
						ob    = b & gtcf_pkg::TRANS_MASK;
						chg_n = 1'b1;
					end
					cn_n = 1'b0;
				end
				if (c_bc != '0)
					bc_n = c_bc - 10'd1;
				if (bc_n == '0)
					ph_n = gtcf_pkg::PH_SUBLEN;
			end
			default: begin
				// done and error phases: pass through, hold everything
			end
		endcase

		case (ph_n)
			gtcf_pkg::PH_DONE:     st = gtcf_pkg::ST_TRAILER;
			gtcf_pkg::PH_BADSIG:   st = gtcf_pkg::ST_BADSIG;
			gtcf_pkg::PH_BADINTRO: st = gtcf_pkg::ST_BADINTRO;
			default:               st = gtcf_pkg::ST_PARSING;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q      <= gtcf_pkg::PH_HEADER;
			byte_count_q <= '0;
			pal_len_q    <= '0;
			in_gce_q     <= 1'b0;
			clear_next_q <= 1'b0;
			changed_q    <= 1'b0;
		end else if (accept) begin
			phase_q      <= ph_n;
			byte_count_q <= bc_n;
			pal_len_q    <= pal_n;
			in_gce_q     <= gce_n;
			clear_next_q <= cn_n;
			changed_q    <= chg_n;
		end
	end

	// ---- output register ----
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (s_tready) begin
			valid_s1 <= s_tvalid;
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			out_byte_s1 <= ob;
			status_s1   <= st;
			changed_s1  <= chg_n;
		end
	end

	assign m_tvalid = valid_s1;
	assign m_tdata  = {5'd0, changed_s1, status_s1, out_byte_s1};

	// ---- assertions ----

	// a pending flag clear only exists at the start of a 4-byte GCE block
	a_clear_next_ctx: assert property (@(posedge clk) disable iff (!arst_n)
		clear_next_q |-> (phase_q == gtcf_pkg::PH_SUBDATA && in_gce_q
			&& byte_count_q == 10'd4))
		else $error("clear_next set outside a GCE length-4 block");

	// changed only rises when clearing was enabled for that byte
	a_changed_enable: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(changed_q) |-> $past(clear_enable_q))
		else $error("changed set while clearing disabled");

	// terminal phases hold until a new file starts
	a_terminal_hold: assert property (@(posedge clk) disable iff (!arst_n)
		(accept && !s_tuser && (phase_q == gtcf_pkg::PH_DONE
			|| phase_q == gtcf_pkg::PH_BADSIG || phase_q == gtcf_pkg::PH_BADINTRO))
		|=> phase_q == $past(phase_q))
		else $error("terminal phase left without start_file");

	// every accepted byte produces a result
	a_accept_result: assert property (@(posedge clk) disable iff (!arst_n)
		accept |=> m_tvalid)
		else $error("accepted item produced no result");

endmodule
`default_nettype wire
